[hdl/ppdsp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the ping-pong DAC sample player.
// No dependencies; imported by ppdsp_ctrl, ppdsp_out and the top level.
package ppdsp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int INDEX_W   = 8;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;
    localparam int DAC_SHIFT = 5;
    localparam logic [SAMPLE_W-1:0] DAC_FAST_MODE = 16'h4000;

    // Item kind carried on s_tuser; code 3 is unused and does nothing
    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_SUBMIT = 2'd1,
        MODE_TICK   = 2'd2
    } mode_t;

    // Per-transaction tag that follows the sample store read
    typedef struct packed {
        logic valid;
        logic tick;
        logic needs_frame;
    } issue_t;

endpackage

[hdl/ppdsp_ram.sv]
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module ppdsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle; read data holds when not reading
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

[hdl/ppdsp_ctrl.sv]
`timescale 1ns / 1ps
// Playback control: bank/offset/filled state, clearing sweep, store access.
// Depends on ppdsp_pkg.
module ppdsp_ctrl
    import ppdsp_pkg::*;
#(
    parameter int FRAME_SIZE = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [1:0]                        mode,
    input  logic [INDEX_W-1:0]                write_index,
    input  logic [SAMPLE_W-1:0]               write_sample,
    input  logic                              take,
    output logic                              ram_en,
    output logic                              ram_we,
    output logic [$clog2(2*FRAME_SIZE)-1:0]   ram_addr,
    output logic [SAMPLE_W-1:0]               ram_wdata,
    output issue_t                            issue
);

    localparam int AW = $clog2(2 * FRAME_SIZE);
    localparam int OW = $clog2(FRAME_SIZE);
    localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;

    logic          clearing_reg;
    logic [AW-1:0] clear_addr_reg;
    logic [OW-1:0] offset_reg, offset_next;
    logic          bank_reg, bank_next;
    logic          filled_reg, filled_next;

    logic          accept;
    logic [IW-1:0] idx_ext;
    logic [IW-1:0] wr_sum;
    logic [AW-1:0] rd_addr;
    logic [OW-1:0] offset_inc;

    assign s_tready = !clearing_reg && take;
    assign accept   = s_tvalid && s_tready;

    // Store addresses: write bank is the one not playing
    assign idx_ext    = IW'(write_index);
    assign wr_sum     = (bank_reg ? '0 : IW'(FRAME_SIZE)) + idx_ext;
    assign rd_addr    = (bank_reg ? AW'(FRAME_SIZE) : '0) + AW'(offset_reg);
    assign offset_inc = (offset_reg == OW'(FRAME_SIZE - 1)) ? '0 : offset_reg + OW'(1);

    // Item decode and next state
    always_comb begin
        offset_next = offset_reg;
        bank_next   = bank_reg;
        filled_next = filled_reg;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = wr_sum[AW-1:0];
        ram_wdata   = write_sample;
        if (clearing_reg) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clear_addr_reg;
            ram_wdata = '0;
        end else if (accept) begin
            unique case (mode)
                MODE_WRITE: begin
                    if (idx_ext < IW'(FRAME_SIZE)) begin
                        ram_en = 1'b1;
                        ram_we = 1'b1;
                    end
                end
                MODE_SUBMIT: begin
                    filled_next = 1'b1;
                end
                MODE_TICK: begin
                    ram_en      = 1'b1;
                    ram_addr    = rd_addr;
                    offset_next = offset_inc;
                    if (offset_inc == '0 && filled_reg) begin
                        filled_next = 1'b0;
                        bank_next   = !bank_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign issue.valid       = accept;
    assign issue.tick        = accept && (mode == MODE_TICK);
    assign issue.needs_frame = !filled_next;

    // State registers and post-reset clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            offset_reg     <= '0;
            bank_reg       <= 1'b0;
            filled_reg     <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
                if (clear_addr_reg == AW'(2 * FRAME_SIZE - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            offset_reg <= offset_next;
            bank_reg   <= bank_next;
            filled_reg <= filled_next;
        end
    end

    no_accept_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn) clearing_reg |-> !accept)
        else $error("transaction accepted during store clear");

    clear_ends_at_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        clearing_reg && clear_addr_reg == AW'(2 * FRAME_SIZE - 1) |=> !clearing_reg)
        else $error("clear sweep did not end at last entry");

    submit_sets_filled: assert property (
        @(posedge aclk) disable iff (!aresetn)
        accept && mode == MODE_SUBMIT |=> filled_reg)
        else $error("submit did not mark frame filled");

    swap_only_on_wrap: assert property (
        @(posedge aclk) disable iff (!aresetn)
        bank_next != bank_reg |-> issue.tick && offset_inc == '0 && filled_reg)
        else $error("bank swap outside frame wrap");

endmodule

[hdl/ppdsp_out.sv]
`timescale 1ns / 1ps
// Result path: tag stage aligned with the store read, then the output register.
// Depends on ppdsp_pkg.
module ppdsp_out
    import ppdsp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  issue_t              issue,
    input  logic [SAMPLE_W-1:0] ram_rdata,
    output logic                take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser
);

    issue_t                p1_reg;
    logic                  out_valid_reg;
    logic [SAMPLE_W-1:0]   out_word_reg;
    logic                  out_tick_reg;
    logic                  out_need_reg;
    logic                  advance;
    logic [SAMPLE_W-1:0]   word_next;

    // Stage 1 moves on when the output register is free or draining
    assign advance = p1_reg.valid && (!out_valid_reg || m_tready);
    assign take    = !p1_reg.valid || advance;

    assign word_next = p1_reg.tick ? ((ram_rdata >> DAC_SHIFT) | DAC_FAST_MODE) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                p1_reg <= issue;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= word_next;
            out_tick_reg <= p1_reg.tick;
            out_need_reg <= p1_reg.needs_frame;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - SAMPLE_W - 1){1'b0}}, out_need_reg, out_word_reg};
    assign m_tuser  = out_tick_reg;

    tick_word_has_mode_bit: assert property (
        @(posedge aclk) disable iff (!aresetn) m_tvalid && m_tuser |-> m_tdata[14])
        else $error("DAC word without fast mode bit");

    non_tick_word_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[SAMPLE_W-1:0] == '0)
        else $error("non-tick result carries a DAC word");

endmodule

[hdl/ping_pong_dac_sample_player.sv]
`timescale 1ns / 1ps
// Ping-pong DAC sample player: top level.
// Depends on ppdsp_pkg, ppdsp_ram, ppdsp_ctrl, ppdsp_out.
//
// Input channel (s_): one transaction per item. s_tuser is the item kind:
// write a sample into the bank not playing, submit that bank as filled, or
// tick, which plays the next sample of the play bank. Code 3 does nothing.
// Output channel (m_): exactly one transaction per input item, in order.
// m_tuser marks a tick result; m_tdata carries the DAC word, (sample >> 5)
// with the fast mode bit, and needs_frame, set while the write bank is not
// submitted. At frame wrap the banks swap if the write bank was submitted,
// otherwise the frame replays.
// Throughput: one item per cycle while m_tready stays high; the single store
// port is used by at most one write or one read per item. A result passes
// through the tag stage, aligned with the store read, then the output register.
// While the receiver stalls, one result waits in the output register and one
// more item is taken in behind it, then s_tready drops. After reset the store
// is swept to zero, one entry a cycle, all 2*FRAME_SIZE with s_tready low.
module ping_pong_dac_sample_player
    import ppdsp_pkg::*;
#(
    parameter int FRAME_SIZE = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] write_index, [23:8] write_sample
    input  logic [1:0]          s_tuser,   // [1:0] mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [15:0] dac_word, [16] needs_frame, rest 0
    output logic                m_tuser    // [0] dac_word_valid
);

    localparam int AW = $clog2(2 * FRAME_SIZE);

    logic                ram_en;
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                take;
    issue_t              issue;

    ppdsp_ctrl #(
        .FRAME_SIZE (FRAME_SIZE)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .mode         (s_tuser),
        .write_index  (s_tdata[INDEX_W-1:0]),
        .write_sample (s_tdata[INDEX_W+SAMPLE_W-1:INDEX_W]),
        .take         (take),
        .ram_en       (ram_en),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .issue        (issue)
    );

    ppdsp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (2 * FRAME_SIZE)
    ) u_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    ppdsp_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .ram_rdata (ram_rdata),
        .take      (take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
